// ===== rtl/range_max_segment_tree_macros.svh =====
// Assertion helpers for the range maximum segment tree.
`ifndef RANGE_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define RMST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define RMST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rmst_pkg.sv =====
package rmst_pkg;

   localparam int DATA_W = 32;
   localparam int CFG_W  = 17;
   localparam int IDX_W  = 16;

   // Every query's running maximum starts from this floor.
   localparam logic signed [DATA_W-1:0] FLOOR_VALUE = -32'sd10000000;

   localparam logic [CFG_W-1:0] LEAVES_RESET = 17'h10000;

   typedef enum logic {
      FUNC_UPDATE = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_DOWN,
      ST_U_UP,
      ST_U_MAX,
      ST_Q_VISIT,
      ST_Q_ACC,
      ST_Q_POP
   } state_type;

   // Classification of the node under the walker against the item's bounds.
   typedef struct packed {
      logic disjoint;
      logic covered;
      logic leaf;
      logic go_left;
   } step_type;

endpackage

// ===== rtl/rmst_ram.sv =====
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rmst_node_step.sv =====
module rmst_node_step #(
   parameter int LEAF_W = 16
) (
   input  logic [LEAF_W-1:0]          seg_start,
   input  logic [LEAF_W-1:0]          seg_end,
   input  logic [rmst_pkg::IDX_W-1:0] bound_lo,
   input  logic [rmst_pkg::IDX_W-1:0] bound_hi,
   output logic [LEAF_W-1:0]          seg_mid,
   output rmst_pkg::step_type         flags
);

   localparam int CMP_W = (LEAF_W > rmst_pkg::IDX_W) ? LEAF_W : rmst_pkg::IDX_W;

   logic [LEAF_W:0]  seg_sum;
   logic [CMP_W-1:0] s_x;
   logic [CMP_W-1:0] e_x;
   logic [CMP_W-1:0] m_x;
   logic [CMP_W-1:0] lo_x;
   logic [CMP_W-1:0] hi_x;

   always_comb begin
      seg_sum = {1'b0, seg_start} + {1'b0, seg_end};
      seg_mid = seg_sum[LEAF_W:1];
      s_x     = CMP_W'(seg_start);
      e_x     = CMP_W'(seg_end);
      m_x     = CMP_W'(seg_mid);
      lo_x    = CMP_W'(bound_lo);
      hi_x    = CMP_W'(bound_hi);

      flags.disjoint = (e_x < lo_x) || (hi_x < s_x);
      flags.covered  = (lo_x <= s_x) && (e_x <= hi_x);
      flags.leaf     = (seg_start == seg_end);
      // For an update the low bound is the leaf position.
      flags.go_left  = (lo_x <= m_x);
   end

endmodule

// ===== rtl/range_max_segment_tree.sv =====
// Range maximum segment tree with point updates.
// Items enter on the req_ ports: an item is taken at a clock edge where start is
// high and busy is low. req_func selects a point update (write req_new_value to
// leaf req_first_index, no result) or a range query over the inclusive leaf range
// req_first_index .. req_last_index. A query gives one result on
// rsp_range_maximum, marked by rsp_valid for exactly one cycle; the receiver
// cannot stall it. Empty or outside ranges return -10000000.
// The tree shape follows leaves_in_use, written on the csr_ port; csr_ready is
// always high, and writes are meant to land only while busy is low.
// One node walker drives a single-port node memory and one shared signed
// comparator. An update walks down from the root one level per step to the
// leaf (16 levels below the root at the default size) and writes the leaf,
// then reads the sibling and writes the parent at each level up, with a last
// step at the root. A query visits each node, with an extra accumulate step
// per fully covered node and at most about four nodes visited per level; the
// result strobes in the cycle after the walk ends.
// Reset clears control state and then sweeps the node memory to zero, one entry
// per cycle, over all 2*MAX_LEAVES entries; busy stays high during that sweep.
`include "range_max_segment_tree_macros.svh"

module range_max_segment_tree #(
   parameter int MAX_LEAVES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [15:0]        req_first_index,
   input  logic [15:0]        req_last_index,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_range_maximum,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [16:0]        csr_leaves_in_use
);

   localparam int LEAF_W  = $clog2(MAX_LEAVES);
   localparam int NODE_W  = LEAF_W + 2;
   localparam int SLOTS   = 2 * MAX_LEAVES;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int STACK_D = LEAF_W + 1;
   localparam int DEP_W   = $clog2(STACK_D);
   localparam int DATA_W  = rmst_pkg::DATA_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);
   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

   // Control state.
   rmst_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [rmst_pkg::CFG_W-1:0] leaves_ff;
   logic [DEP_W-1:0]    depth_ff, depth_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Walker payload.
   logic [NODE_W-1:0]          node_ff, node_in;
   logic [LEAF_W-1:0]          s_ff, s_in;
   logic [LEAF_W-1:0]          e_ff, e_in;
   logic [rmst_pkg::IDX_W-1:0] lo_ff, lo_in;
   logic [rmst_pkg::IDX_W-1:0] hi_ff, hi_in;
   logic signed [DATA_W-1:0]   value_ff, value_in;
   logic signed [DATA_W-1:0]   acc_ff, acc_in;
   logic signed [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                       rd_oob_ff, rd_oob_in;
   logic [LEAF_W-1:0]          ends_ff [STACK_D];
   logic                       push_en;

   // Effective tree size.
   logic [LEAF_W:0]   n_eff;
   logic [LEAF_W-1:0] n_last;
   logic              upd_in_range;

   // Node step and neighbors.
   logic [LEAF_W-1:0]   seg_mid;
   rmst_pkg::step_type  flags;
   logic [NODE_W-1:0]   sib_node;
   logic [NODE_W-1:0]   par_node;
   logic                node_in_store;
   logic                sib_in_store;
   logic                par_in_store;
   logic [LEAF_W-1:0]   stack_top;

   // Memory port.
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_addr;
   logic [DATA_W-1:0]        mem_wdata;
   logic [DATA_W-1:0]        mem_rdata;
   logic signed [DATA_W-1:0] rd_val;

   // Shared comparator.
   logic signed [DATA_W-1:0] cmp_a;
   logic signed [DATA_W-1:0] cmp_max;

   rmst_node_step #(
      .LEAF_W(LEAF_W)
   ) u_step (
      .seg_start(s_ff),
      .seg_end  (e_ff),
      .bound_lo (lo_ff),
      .bound_hi (hi_ff),
      .seg_mid  (seg_mid),
      .flags    (flags)
   );

   rmst_ram #(
      .WIDTH(DATA_W),
      .DEPTH(SLOTS)
   ) u_nodes (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   // A register value of zero counts as one leaf; values past the store clamp.
   always_comb begin
      if (leaves_ff == '0) begin
         n_eff = (LEAF_W + 1)'(1);
      end else if (32'(leaves_ff) > 32'(MAX_LEAVES)) begin
         n_eff = (LEAF_W + 1)'(MAX_LEAVES);
      end else begin
         n_eff = (LEAF_W + 1)'(leaves_ff);
      end
      n_last       = LEAF_W'(n_eff - 1'b1);
      upd_in_range = 32'(req_first_index) < 32'(n_eff);
   end

   // Node indices past the store read as zero and drop writes; that only
   // happens when MAX_LEAVES is not a power of two.
   always_comb begin
      sib_node      = node_ff ^ ROOT_NODE;
      par_node      = node_ff >> 1;
      node_in_store = 32'(node_ff) < 32'(SLOTS);
      sib_in_store  = 32'(sib_node) < 32'(SLOTS);
      par_in_store  = 32'(par_node) < 32'(SLOTS);
      stack_top     = ends_ff[DEP_W'(depth_ff - 1'b1)];
      rd_val        = rd_oob_ff ? '0 : $signed(mem_rdata);
      cmp_a         = (state_ff == rmst_pkg::ST_U_MAX) ? value_ff : acc_ff;
      cmp_max       = (rd_val > cmp_a) ? rd_val : cmp_a;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_IDLE: begin
            if (start) begin
               if (req_func == rmst_pkg::FUNC_QUERY) begin
                  state_in = rmst_pkg::ST_Q_VISIT;
               end else if (upd_in_range) begin
                  state_in = rmst_pkg::ST_U_DOWN;
               end
            end
         end
         rmst_pkg::ST_U_DOWN: begin
            if (flags.leaf) begin
               state_in = rmst_pkg::ST_U_UP;
            end
         end
         rmst_pkg::ST_U_UP: begin
            if (node_ff == ROOT_NODE) begin
               state_in = rmst_pkg::ST_IDLE;
            end else begin
               state_in = rmst_pkg::ST_U_MAX;
            end
         end
         rmst_pkg::ST_U_MAX: begin
            state_in = rmst_pkg::ST_U_UP;
         end
         rmst_pkg::ST_Q_VISIT: begin
            if (flags.disjoint) begin
               state_in = rmst_pkg::ST_Q_POP;
            end else if (flags.covered) begin
               state_in = rmst_pkg::ST_Q_ACC;
            end
         end
         rmst_pkg::ST_Q_ACC: begin
            state_in = rmst_pkg::ST_Q_POP;
         end
         rmst_pkg::ST_Q_POP: begin
            if (depth_ff == '0) begin
               state_in = rmst_pkg::ST_IDLE;
            end else if (node_ff[0] == 1'b0) begin
               state_in = rmst_pkg::ST_Q_VISIT;
            end
         end
         default: begin
            state_in = rmst_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      clear_addr_in = clear_addr_ff;
      node_in       = node_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      depth_in      = depth_ff;
      value_in      = value_ff;
      acc_in        = acc_ff;
      rd_oob_in     = rd_oob_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      push_en       = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = node_ff[ADDR_W-1:0];
      mem_wdata     = value_ff;

      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_addr      = clear_addr_ff;
            mem_wdata     = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
         end
         rmst_pkg::ST_IDLE: begin
            if (start) begin
               node_in  = ROOT_NODE;
               s_in     = '0;
               e_in     = n_last;
               lo_in    = req_first_index;
               hi_in    = req_last_index;
               depth_in = '0;
               value_in = req_new_value;
               acc_in   = rmst_pkg::FLOOR_VALUE;
            end
         end
         rmst_pkg::ST_U_DOWN: begin
            if (flags.leaf) begin
               mem_we    = node_in_store;
               mem_wdata = value_ff;
               value_in  = node_in_store ? value_ff : '0;
            end else if (flags.go_left) begin
               node_in = {node_ff[NODE_W-2:0], 1'b0};
               e_in    = seg_mid;
            end else begin
               node_in = {node_ff[NODE_W-2:0], 1'b1};
               s_in    = LEAF_W'(seg_mid + 1'b1);
            end
         end
         rmst_pkg::ST_U_UP: begin
            mem_addr  = sib_node[ADDR_W-1:0];
            rd_oob_in = !sib_in_store;
         end
         rmst_pkg::ST_U_MAX: begin
            mem_we    = par_in_store;
            mem_addr  = par_node[ADDR_W-1:0];
            mem_wdata = cmp_max;
            value_in  = par_in_store ? cmp_max : '0;
            node_in   = par_node;
         end
         rmst_pkg::ST_Q_VISIT: begin
            if (flags.disjoint) begin
               rd_oob_in = rd_oob_ff;
            end else if (flags.covered) begin
               rd_oob_in = !node_in_store;
            end else begin
               push_en  = 1'b1;
               node_in  = {node_ff[NODE_W-2:0], 1'b0};
               e_in     = seg_mid;
               depth_in = depth_ff + 1'b1;
            end
         end
         rmst_pkg::ST_Q_ACC: begin
            // A covered root is the whole answer and skips the floor.
            acc_in = (node_ff == ROOT_NODE) ? rd_val : cmp_max;
         end
         rmst_pkg::ST_Q_POP: begin
            if (depth_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end else if (node_ff[0] == 1'b0) begin
               node_in = node_ff | ROOT_NODE;
               s_in    = LEAF_W'(e_ff + 1'b1);
               e_in    = stack_top;
            end else begin
               node_in  = par_node;
               depth_in = depth_ff - 1'b1;
               e_in     = stack_top;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rmst_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         leaves_ff     <= rmst_pkg::LEAVES_RESET;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            leaves_ff <= csr_leaves_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      value_ff    <= value_in;
      acc_ff      <= acc_in;
      rd_oob_ff   <= rd_oob_in;
      rsp_data_ff <= rsp_data_in;
      if (push_en) begin
         ends_ff[depth_ff] <= e_ff;
      end
   end

   assign busy              = (state_ff != rmst_pkg::ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_maximum = rsp_data_ff;

   // A result strobes only as the walker lands back in idle.
   `RMST_ASSERT_SAME(a_rsp_in_idle, clock, reset, rsp_valid_ff,
      state_ff == rmst_pkg::ST_IDLE, "result strobe outside idle")

   // No item can produce a result in the cycle right after it is taken.
   `RMST_ASSERT_NEXT(a_no_early_rsp, clock, reset, start && !busy,
      !rsp_valid_ff, "result right after accept")

   // Unwinding to depth zero always means the walker is at the root.
   `RMST_ASSERT_SAME(a_pop_root, clock, reset,
      (state_ff == rmst_pkg::ST_Q_POP) && (depth_ff == '0),
      node_ff == ROOT_NODE, "stack depth and node disagree")

endmodule

// ===== tb/sv/range_max_segment_tree_checker.sv =====
module range_max_segment_tree_checker #(
   parameter int MAX_LEAVES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 req_func,
   input  logic [rmst_pkg::IDX_W-1:0]           req_first_index,
   input  logic [rmst_pkg::IDX_W-1:0]           req_last_index,
   input  logic signed [rmst_pkg::DATA_W-1:0]   req_new_value,
   input  logic                                 rsp_valid,
   input  logic signed [rmst_pkg::DATA_W-1:0]   rsp_range_maximum,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [rmst_pkg::CFG_W-1:0]           csr_leaves_in_use,
   output int                                   mismatch_count,
   output int                                   results_pending
);
   import rmst_pkg::*;

   localparam int unsigned NODE_SLOTS = 2 * MAX_LEAVES;

   typedef struct {
      logic [IDX_W-1:0]         lo;
      logic [IDX_W-1:0]         hi;
      logic signed [DATA_W-1:0] peak;
   } query_rec;

   logic signed [DATA_W-1:0] node_peak [0:NODE_SLOTS-1];
   logic [CFG_W-1:0]         leaves_cfg;
   query_rec                 expected_peaks [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // A register value of zero means one leaf; anything past the store is clipped.
   function automatic int unsigned tree_span();
      if (leaves_cfg == '0) begin
         return 1;
      end
      if (leaves_cfg > MAX_LEAVES) begin
         return MAX_LEAVES;
      end
      return leaves_cfg;
   endfunction

   // Nodes past the store only exist for sizes that are not a power of two.
   function automatic logic signed [DATA_W-1:0] node_read(input int unsigned node);
      return (node < NODE_SLOTS) ? node_peak[node] : '0;
   endfunction

   function automatic void node_write(input int unsigned node,
                                      input logic signed [DATA_W-1:0] value);
      if (node < NODE_SLOTS) begin
         node_peak[node] = value;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] range_peak(
      input int unsigned s, input int unsigned e,
      input int unsigned lo, input int unsigned hi, input int unsigned node);
      int unsigned              mid;
      logic signed [DATA_W-1:0] left_peak;
      logic signed [DATA_W-1:0] right_peak;
      if (e < lo || hi < s) begin
         return FLOOR_VALUE;
      end
      if (lo <= s && e <= hi) begin
         return node_read(node);
      end
      mid = (s + e) / 2;
      left_peak = range_peak(s, mid, lo, hi, node * 2);
      right_peak = range_peak(mid + 1, e, lo, hi, node * 2 + 1);
      return (left_peak > right_peak) ? left_peak : right_peak;
   endfunction

   function automatic void store_leaf(
      input int unsigned s, input int unsigned e, input int unsigned node,
      input int unsigned pos, input logic signed [DATA_W-1:0] value);
      int unsigned              mid;
      logic signed [DATA_W-1:0] left_peak;
      logic signed [DATA_W-1:0] right_peak;
      if (pos < s || e < pos) begin
         return;
      end
      if (s == e) begin
         node_write(node, value);
         return;
      end
      mid = (s + e) / 2;
      store_leaf(s, mid, node * 2, pos, value);
      store_leaf(mid + 1, e, node * 2 + 1, pos, value);
      left_peak = node_read(node * 2);
      right_peak = node_read(node * 2 + 1);
      node_write(node, (left_peak > right_peak) ? left_peak : right_peak);
   endfunction

   // Results are matched before new items, since a result always belongs to an
   // earlier query.
   always @(posedge clock) begin : watch
      query_rec head;
      query_rec fresh;
      if (reset) begin
         foreach (node_peak[i]) node_peak[i] = '0;
         leaves_cfg = LEAVES_RESET;
         expected_peaks.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_peaks.size() == 0) begin
               report_mismatch($sformatf("result %0d with no query waiting",
                                         rsp_range_maximum));
            end else begin
               head = expected_peaks.pop_front();
               if (rsp_range_maximum !== head.peak) begin
                  report_mismatch($sformatf("query %0d..%0d gave %0d, expected %0d",
                                            head.lo, head.hi, rsp_range_maximum,
                                            head.peak));
               end
            end
         end
         if (start && !busy) begin
            if (func_type'(req_func) == FUNC_QUERY) begin
               fresh.lo = req_first_index;
               fresh.hi = req_last_index;
               fresh.peak = range_peak(0, tree_span() - 1, req_first_index,
                                       req_last_index, 1);
               expected_peaks.insert(expected_peaks.size(), fresh);
            end else begin
               store_leaf(0, tree_span() - 1, 1, req_first_index, req_new_value);
            end
         end
         if (csr_valid && csr_ready) begin
            leaves_cfg = csr_leaves_in_use;
         end
      end
      results_pending = expected_peaks.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import rmst_pkg::*;

   localparam int MAX_LEAVES    = 65536;
   // Each random phase runs this many items that the block acts on.
   localparam int PHASE_ITEMS   = 63;
   // Past this many items the sender stops idling.
   localparam int QUIET_TAIL_AT = 720;
   // Covers an update walk at full depth with margin.
   localparam int WALK_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 300;
   // Reset sweep of all 131072 entries plus the slowest plausible item stream,
   // taken several times over.
   localparam longint RUN_LIMIT = 64'd20_000_000;

   localparam logic [IDX_W-1:0] LAST_SLOT = 16'hFFFF;
   localparam logic signed [DATA_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] BOTTOM_VALUE = 32'sh8000_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_func = FUNC_UPDATE;
   logic [IDX_W-1:0]         req_first_index = '0;
   logic [IDX_W-1:0]         req_last_index = '0;
   logic signed [DATA_W-1:0] req_new_value = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_range_maximum;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CFG_W-1:0]         csr_leaves_in_use = LEAVES_RESET;

   int mismatch_count;
   int results_pending;

   // Stimulus bookkeeping, used for pacing and for the closing summary.
   int unsigned span_now = MAX_LEAVES;
   int          acted_items = 0;
   int          update_count = 0;
   int          ignored_updates = 0;
   int          query_count = 0;
   int          setting_count = 0;
   bit          idle_enable = 1'b1;

   always #5 clock = ~clock;

   range_max_segment_tree #(
      .MAX_LEAVES(MAX_LEAVES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_first_index  (req_first_index),
      .req_last_index   (req_last_index),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_range_maximum(rsp_range_maximum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_leaves_in_use(csr_leaves_in_use)
   );

   range_max_segment_tree_checker #(
      .MAX_LEAVES(MAX_LEAVES)
   ) tree_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_first_index  (req_first_index),
      .req_last_index   (req_last_index),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_range_maximum(rsp_range_maximum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_leaves_in_use(csr_leaves_in_use),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   // Hands one item to the block. Start is left high after acceptance so that
   // back-to-back items never drop it within a single time step; whoever next
   // lets time pass without a new item lowers it first.
   task automatic send_item(input func_type f, input logic [IDX_W-1:0] first,
                            input logic [IDX_W-1:0] last,
                            input logic signed [DATA_W-1:0] value);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_first_index <= first;
      req_last_index <= last;
      req_new_value <= value;
      // Busy is sampled before the edge updates it, so the edge at which it
      // reads low is the one that took the item.
      do @(posedge clock); while (busy);
      if (f == FUNC_QUERY) begin
         query_count++;
         acted_items++;
      end else if (first >= span_now) begin
         ignored_updates++;
      end else begin
         update_count++;
         acted_items++;
      end
      if (acted_items >= QUIET_TAIL_AT) begin
         idle_enable = 1'b0;
      end
   endtask

   // Brings the block to rest: every query answered, then enough cycles for a
   // trailing update walk, then busy low.
   task automatic wait_for_quiet();
      start <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (WALK_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Only called with the block at rest.
   task automatic write_leaves(input logic [CFG_W-1:0] leaves);
      csr_valid <= 1'b1;
      csr_leaves_in_use <= leaves;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (leaves == '0) begin
         span_now = 1;
      end else if (leaves > MAX_LEAVES) begin
         span_now = MAX_LEAVES;
      end else begin
         span_now = leaves;
      end
      setting_count++;
   endtask

   // Mostly leaves that exist, with a share of the boundary just past the last
   // leaf and of fully random indexes so that every index bit toggles.
   function automatic logic [IDX_W-1:0] pick_index(input int unsigned span);
      case ($urandom_range(0, 9))
         0: return IDX_W'($urandom());
         1: return IDX_W'(span);
         2: return IDX_W'(span - 1);
         3: return '0;
         default: return IDX_W'($urandom_range(0, span - 1));
      endcase
   endfunction

   // Small values give plenty of ties; values near the floor and at the ends
   // of the signed range exercise the clamp of every partial maximum.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int offset;
      offset = $urandom_range(0, 200);
      case ($urandom_range(0, 7))
         0, 1: return $urandom();
         2: return FLOOR_VALUE + (offset % 5) - 2;
         3: return offset[0] ? TOP_VALUE : BOTTOM_VALUE;
         default: return offset - 100;
      endcase
   endfunction

   task automatic random_item();
      func_type         f;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
      logic [IDX_W-1:0] swap;
      f = ($urandom_range(0, 99) < 45) ? FUNC_UPDATE : FUNC_QUERY;
      first = pick_index(span_now);
      last = pick_index(span_now);
      // Most queries are ordered ranges; the rest may come out empty.
      if (f == FUNC_QUERY && first > last && $urandom_range(0, 7) != 0) begin
         swap = first;
         first = last;
         last = swap;
      end
      send_item(f, first, last, pick_value());
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("range_max_segment_tree regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] plan [12];
      int               phase_start;
      plan = '{17'd7, 17'd1, 17'd0, 17'd2, 17'd100, 17'd65536, 17'd3, 17'd131071,
               17'd1000, 17'd16, 17'd65535, 17'd37};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its store after reset with busy high; the first item
      // simply waits in the handshake until the sweep is done.

      // Full-size tree at its reset shape: a freshly cleared store, both ends
      // of the value range on both end leaves, empty ranges and sub-floor
      // leaves.
      send_item(FUNC_QUERY, '0, LAST_SLOT, '0);
      send_item(FUNC_UPDATE, '0, LAST_SLOT, TOP_VALUE);
      send_item(FUNC_UPDATE, LAST_SLOT, '0, BOTTOM_VALUE);
      send_item(FUNC_QUERY, '0, LAST_SLOT, '0);
      send_item(FUNC_QUERY, LAST_SLOT, LAST_SLOT, '0);
      send_item(FUNC_QUERY, 16'd1, 16'hFFFE, '0);
      send_item(FUNC_QUERY, 16'd9, 16'd3, '0);
      send_item(FUNC_UPDATE, 16'd12345, 16'd0, -32'sd20000000);
      send_item(FUNC_QUERY, 16'd12345, 16'd12345, '0);

      // A register of zero stands for a single leaf: updates past it are
      // dropped and queries are clipped to leaf zero.
      wait_for_quiet();
      write_leaves('0);
      send_item(FUNC_UPDATE, '0, '0, -32'sd5);
      send_item(FUNC_UPDATE, 16'd1, '0, 32'sd99);
      send_item(FUNC_QUERY, '0, '0, '0);
      send_item(FUNC_QUERY, '0, LAST_SLOT, '0);
      send_item(FUNC_QUERY, 16'd1, LAST_SLOT, '0);

      // All register bits set is past the store and means the largest tree;
      // the store is kept, so stale nodes are read under the new shape.
      wait_for_quiet();
      write_leaves('1);
      send_item(FUNC_QUERY, '0, LAST_SLOT, '0);
      send_item(FUNC_QUERY, '0, '0, '0);

      // Five leaves all at or below the floor, then one just above it.
      wait_for_quiet();
      write_leaves(17'd5);
      send_item(FUNC_UPDATE, 16'd0, '0, -32'sd10000001);
      send_item(FUNC_UPDATE, 16'd1, '0, BOTTOM_VALUE);
      send_item(FUNC_UPDATE, 16'd2, '0, -32'sd12345678);
      send_item(FUNC_UPDATE, 16'd3, '0, -32'sd99999999);
      send_item(FUNC_UPDATE, 16'd4, '0, FLOOR_VALUE);
      send_item(FUNC_QUERY, '0, 16'd4, '0);
      send_item(FUNC_QUERY, 16'd2, 16'd9, '0);
      send_item(FUNC_QUERY, 16'd7, 16'd20, '0);
      send_item(FUNC_UPDATE, 16'd4, '0, -32'sd9999999);
      send_item(FUNC_QUERY, '0, LAST_SLOT, '0);

      // Random phases, one per leaf count. Sender idling is switched off for
      // some phases so that long back-to-back stretches occur as well.
      foreach (plan[p]) begin
         wait_for_quiet();
         write_leaves(plan[p]);
         if (acted_items < QUIET_TAIL_AT) begin
            idle_enable = ($urandom_range(0, 2) != 0);
         end
         phase_start = acted_items;
         while (acted_items - phase_start < PHASE_ITEMS) begin
            random_item();
         end
      end

      start <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d leaf updates (%0d more outside the tree) and %0d range queries",
               update_count, ignored_updates, query_count);
      $display("across %0d leaf-count settings, from a single leaf up past the store size.",
               setting_count);
      if (mismatch_count == 0) begin
         $display("range_max_segment_tree regression: pass");
      end else begin
         $display("range_max_segment_tree regression: fail");
      end
      $finish;
   end

endmodule
